/* design/emr_pkg.sv */
// shared types, constants and helper functions for the eller maze row generator
`timescale 1ns / 1ps

package emr_pkg;

    localparam int MAX_COLUMNS = 32;
    localparam int LBL_W       = 6;
    localparam int IDX_W       = 5;
    localparam int CNT_W       = 6;
    localparam int HORIZ_W     = 31;
    localparam int VERT_W      = 32;
    localparam int NUM_LBLS    = 64;

    localparam logic [CNT_W-1:0] COLUMNS_RESET = 6'd16;
    localparam logic [CNT_W-1:0] COLUMNS_MIN   = 6'd2;
    localparam logic [CNT_W-1:0] COLUMNS_MAX   = 6'd32;

    typedef logic [1:0] t_cell_op;
    localparam t_cell_op CELL_NOP     = 2'd0;
    localparam t_cell_op CELL_INIT    = 2'd1;
    localparam t_cell_op CELL_MERGE   = 2'd2;
    localparam t_cell_op CELL_RELABEL = 2'd3;

    // command broadcast from the sequencer to every cell
    typedef struct packed {
        t_cell_op               op;
        logic [LBL_W-1:0]       lbl_a;
        logic [LBL_W-1:0]       lbl_b;
        logic [LBL_W-1:0]       lbl_new;
        logic                   tok_start;
        logic                   tok_advance;
    } t_cell_cmd;

    // what each cell reports back
    typedef struct packed {
        logic [LBL_W-1:0]       label;
        logic                   tok;
    } t_cell_stat;

    // clamp a written column count to the supported range
    function automatic logic [CNT_W-1:0] clamp_columns(input logic [CNT_W-1:0] value);
        logic [CNT_W-1:0] res;
        res = value;
        if (value < COLUMNS_MIN) begin
            res = COLUMNS_MIN;
        end else if (value > COLUMNS_MAX) begin
            res = COLUMNS_MAX;
        end
        return res;
    endfunction

    // one bit per column in use
    function automatic logic [MAX_COLUMNS-1:0] col_mask(input logic [CNT_W-1:0] n);
        logic [MAX_COLUMNS:0] m;
        m = ({{MAX_COLUMNS{1'b0}}, 1'b1} << n) - {{MAX_COLUMNS{1'b0}}, 1'b1};
        return m[MAX_COLUMNS-1:0];
    endfunction

endpackage

/* design/emr_in_if.sv */
// input channel of the eller maze row generator
`timescale 1ns / 1ps

interface emr_in_if;
    import emr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [HORIZ_W-1:0]   horiz_random;
    logic [VERT_W-1:0]    vert_random;
    logic                 last_row;

    modport source (output valid, output horiz_random, output vert_random,
                    output last_row, input ready);
    modport sink   (input valid, input horiz_random, input vert_random,
                    input last_row, output ready);
endinterface

/* design/emr_out_if.sv */
// output channel of the eller maze row generator
`timescale 1ns / 1ps

interface emr_out_if;
    import emr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [HORIZ_W-1:0]   east_open;
    logic [VERT_W-1:0]    south_open;

    modport source (output valid, output east_open, output south_open, input ready);
    modport sink   (input valid, input east_open, input south_open, output ready);
endinterface

/* design/eller_maze_row_generator_top.sv */
// top level of the eller maze row generator: cell chain and sequencer
`timescale 1ns / 1ps

// Eller maze row generator.
// i_in carries one maze row request per transfer: horiz_random, vert_random
// and last_row. o_out returns one transfer per row with east_open and
// south_open. i_cfg_we / i_cfg_data write the column count (clamped to
// 2..32); a write restarts the maze with distinct labels. The user must
// issue it only while the block is idle; the block does not enforce this.
// A row runs through an accept step, n-1 horizontal steps for n columns in
// use, then n vertical steps (or one label restart step on the final row),
// and a finish step that loads the output register once it is free. Both
// passes step one column per cycle as a token walks the cell chain, since
// each decision depends on the labels the previous one left. i_in.ready
// is high only between rows.
// The result waits in an output register; a new row is accepted while it
// waits, and a finished row holds in the sequencer until the receiver
// takes the previous one.
// Reset (i_rst_n low, synchronous) sets 16 columns and labels 0..31.

module eller_maze_row_generator_top
    import emr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    emr_in_if.sink            i_in,
    emr_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_data
);

    t_cell_cmd                    w_cmd;
    t_cell_stat [MAX_COLUMNS-1:0] w_stat;
    logic [MAX_COLUMNS-1:0]       w_tok_left;

    // sequencer: runs both passes and owns the free label pool
    emr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // chain of column cells, token handed left to right
    for (genvar g = 0; g < MAX_COLUMNS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_tok_left[g] = 1'b0;
        end else begin : g_link
            assign w_tok_left[g] = w_stat[g-1].tok;
        end

        emr_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_cmd),
            .i_index    (IDX_W'(g)),
            .i_tok_left (w_tok_left[g]),
            .o_stat     (w_stat[g])
        );
    end

endmodule

/* design/emr_cell.sv */
// one column cell: holds the set label and the scan token of its column
`timescale 1ns / 1ps

module emr_cell
    import emr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_cmd        i_cmd,
    input  logic [IDX_W-1:0] i_index,
    input  logic             i_tok_left,
    output t_cell_stat       o_stat
);

    logic [LBL_W-1:0] r_label;
    logic [LBL_W-1:0] n_label;
    logic             r_tok;
    logic             n_tok;

    always_comb begin
        n_label = r_label;
        n_tok   = r_tok;
        case (i_cmd.op)
            CELL_INIT: begin
                n_label = {1'b0, i_index};
                n_tok   = 1'b0;
            end
            CELL_MERGE: begin
                if (r_label == i_cmd.lbl_a || r_label == i_cmd.lbl_b) begin
                    n_label = i_cmd.lbl_new;
                end
            end
            CELL_RELABEL: begin
                if (r_tok) begin
                    n_label = i_cmd.lbl_new;
                end
            end
            default: begin
                n_label = r_label;
            end
        endcase
        // token walks one cell to the right per advance
        if (i_cmd.tok_start) begin
            n_tok = (i_index == '0);
        end else if (i_cmd.tok_advance) begin
            n_tok = i_tok_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label <= {1'b0, i_index};
            r_tok   <= 1'b0;
        end else begin
            r_label <= n_label;
            r_tok   <= n_tok;
        end
    end

    assign o_stat.label = r_label;
    assign o_stat.tok   = r_tok;

endmodule

/* design/emr_ctrl.sv */
// row sequencer: horizontal and vertical passes, label pool, handshakes
`timescale 1ns / 1ps

module emr_ctrl
    import emr_pkg::*;
(
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    emr_in_if.sink                              i_in,
    emr_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [CNT_W-1:0]                    i_cfg_data,
    input  t_cell_stat [MAX_COLUMNS-1:0]        i_stat,
    output t_cell_cmd                           o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_HORIZ  = 3'd1;
    localparam logic [2:0] ST_VERT   = 3'd2;
    localparam logic [2:0] ST_LINIT  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [IDX_W-1:0]       r_col, n_col;
    logic [CNT_W-1:0]       r_cols, n_cols;
    logic [NUM_LBLS-1:0]    r_used, n_used;
    logic [HORIZ_W-1:0]     r_h, n_h;
    logic [VERT_W-1:0]      r_v, n_v;
    logic                   r_last, n_last;
    logic [MAX_COLUMNS-1:0] r_east, n_east;
    logic [VERT_W-1:0]      r_south, n_south;
    logic                   r_out_valid, n_out_valid;
    logic [HORIZ_W-1:0]     r_out_east, n_out_east;
    logic [VERT_W-1:0]      r_out_south, n_out_south;

    logic [MAX_COLUMNS-1:0] w_tok;
    logic [MAX_COLUMNS-1:0] w_match;
    logic [MAX_COLUMNS-1:0] w_act;
    logic [MAX_COLUMNS-1:0] w_h_ext;
    logic [LBL_W-1:0]       w_cur, w_nxt, w_lo, w_hi, w_fresh;
    logic [CNT_W-1:0]       w_cfg_cols;
    logic                   w_others, w_join, w_open, w_hlast, w_vlast, w_accept;

    // labels at the token and right of it
    always_comb begin
        w_cur = '0;
        w_nxt = '0;
        for (int i = 0; i < MAX_COLUMNS; i++) begin
            w_tok[i] = i_stat[i].tok;
            w_cur    = w_cur | (i_stat[i].label & {LBL_W{i_stat[i].tok}});
        end
        for (int i = 0; i < MAX_COLUMNS - 1; i++) begin
            w_nxt = w_nxt | (i_stat[i+1].label & {LBL_W{i_stat[i].tok}});
        end
        for (int i = 0; i < MAX_COLUMNS; i++) begin
            w_match[i] = (i_stat[i].label == w_cur);
        end
    end

    // lowest label not held by a column in use
    always_comb begin
        w_fresh = '0;
        for (int i = NUM_LBLS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_fresh = LBL_W'(i);
            end
        end
    end

    assign w_act      = col_mask(r_cols);
    assign w_h_ext    = {1'b0, r_h};
    assign w_others   = |(w_match & w_act & ~w_tok);
    assign w_lo       = (w_cur < w_nxt) ? w_cur : w_nxt;
    assign w_hi       = (w_cur < w_nxt) ? w_nxt : w_cur;
    assign w_join     = (w_cur != w_nxt) && (r_last || w_h_ext[r_col]);
    assign w_open     = !w_others || r_v[r_col];
    assign w_hlast    = ({1'b0, r_col} == (r_cols - 6'd2));
    assign w_vlast    = ({1'b0, r_col} == (r_cols - 6'd1));
    assign w_cfg_cols = clamp_columns(i_cfg_data);
    assign w_accept   = i_in.valid && (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_cols      = r_cols;
        n_used      = r_used;
        n_h         = r_h;
        n_v         = r_v;
        n_last      = r_last;
        n_east      = r_east;
        n_south     = r_south;
        n_out_east  = r_out_east;
        n_out_south = r_out_south;
        n_out_valid = r_out_valid && !o_out.ready;
        o_cmd       = '0;
        o_cmd.op    = CELL_NOP;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_h             = i_in.horiz_random;
                    n_v             = i_in.vert_random;
                    n_last          = i_in.last_row;
                    n_col           = '0;
                    n_east          = '0;
                    n_south         = '0;
                    o_cmd.tok_start = 1'b1;
                    n_state         = ST_HORIZ;
                end
            end
            ST_HORIZ: begin
                if (w_join) begin
                    o_cmd.op      = CELL_MERGE;
                    o_cmd.lbl_a   = w_cur;
                    o_cmd.lbl_b   = w_nxt;
                    o_cmd.lbl_new = w_lo;
                    n_used[w_hi]  = 1'b0;
                    n_east[r_col] = 1'b1;
                end
                if (w_hlast) begin
                    if (r_last) begin
                        n_state = ST_LINIT;
                    end else begin
                        o_cmd.tok_start = 1'b1;
                        n_col           = '0;
                        n_state         = ST_VERT;
                    end
                end else begin
                    o_cmd.tok_advance = 1'b1;
                    n_col             = r_col + 5'd1;
                end
            end
            ST_VERT: begin
                if (w_open) begin
                    n_south[r_col] = 1'b1;
                end else begin
                    o_cmd.op        = CELL_RELABEL;
                    o_cmd.lbl_new   = w_fresh;
                    n_used[w_fresh] = 1'b1;
                end
                if (w_vlast) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.tok_advance = 1'b1;
                    n_col             = r_col + 5'd1;
                end
            end
            ST_LINIT: begin
                o_cmd.op = CELL_INIT;
                n_used   = {{(NUM_LBLS-MAX_COLUMNS){1'b0}}, w_act};
                n_state  = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_east  = r_east[HORIZ_W-1:0];
                    n_out_south = r_south;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // column count write restarts the maze
        if (i_cfg_we) begin
            o_cmd.op = CELL_INIT;
            n_cols   = w_cfg_cols;
            n_used   = {{(NUM_LBLS-MAX_COLUMNS){1'b0}}, col_mask(w_cfg_cols)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_col       <= '0;
            r_cols      <= COLUMNS_RESET;
            r_used      <= {{(NUM_LBLS-MAX_COLUMNS){1'b0}}, col_mask(COLUMNS_RESET)};
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_cols      <= n_cols;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h         <= n_h;
        r_v         <= n_v;
        r_last      <= n_last;
        r_east      <= n_east;
        r_south     <= n_south;
        r_out_east  <= n_out_east;
        r_out_south <= n_out_south;
    end

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.east_open  = r_out_east;
    assign o_out.south_open = r_out_south;

`ifndef NO_ASSERTIONS
    // never more distinct labels in use than columns
    a_label_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) <= int'(r_cols))
        else $error("label pool holds more labels than columns");

    // exactly one cell holds the scan token during a pass
    a_token_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HORIZ || r_state == ST_VERT) |-> $onehot(w_tok))
        else $error("scan token lost or duplicated");

    // horizontal pass never looks past the last pair in use
    a_horiz_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HORIZ) |-> ({1'b0, r_col} < (r_cols - 6'd1)))
        else $error("horizontal pass beyond columns in use");

    // final row opens nothing downward
    a_last_south: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_last) |-> (r_south == '0))
        else $error("south opening on final row");
`endif

endmodule

/* bench/emr_row_checker.sv */
// row checker for the eller maze row generator: predicts each row and compares results
`timescale 1ns / 1ps

module emr_row_checker
    import emr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    emr_in_if                 i_in_mon,
    emr_out_if                i_out_mon,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [HORIZ_W-1:0] east;
        logic [VERT_W-1:0]  south;
    } t_row_walls;

    t_row_walls        expected_rows[$];
    logic [LBL_W-1:0]  set_label [MAX_COLUMNS];
    logic [CNT_W-1:0]  maze_columns;
    int                fail_count   = 0;
    int                pending_rows = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_rows;

    function automatic void restart_labels();
        for (int i = 0; i < MAX_COLUMNS; i++) begin
            set_label[i] = LBL_W'(i);
        end
    endfunction

    function automatic void report(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
    endfunction

    // one row of eller's algorithm on the tracked labels
    function automatic t_row_walls carve_row(input logic [HORIZ_W-1:0] h,
                                             input logic [VERT_W-1:0] v,
                                             input logic last);
        t_row_walls             walls;
        int                     n;
        int                     members;
        int                     pick;
        logic [LBL_W-1:0]       a;
        logic [LBL_W-1:0]       b;
        logic [LBL_W-1:0]       lo;
        logic [NUM_LBLS-1:0]    used;
        n = int'(maze_columns);
        if (n > MAX_COLUMNS) n = MAX_COLUMNS;
        if (n < 2) n = 2;
        walls = '0;
        for (int x = 0; x < n - 1; x++) begin
            if (set_label[x] != set_label[x+1] && (last || h[x])) begin
                walls.east[x] = 1'b1;
                a  = set_label[x];
                b  = set_label[x+1];
                lo = (a < b) ? a : b;
                for (int i = 0; i < n; i++) begin
                    if (set_label[i] == a || set_label[i] == b) set_label[i] = lo;
                end
            end
        end
        if (last) begin
            restart_labels();
        end else begin
            for (int x = 0; x < n; x++) begin
                members = 0;
                for (int i = 0; i < n; i++) begin
                    if (set_label[i] == set_label[x]) members++;
                end
                if (members == 1 || v[x]) begin
                    walls.south[x] = 1'b1;
                end else begin
                    used = '0;
                    for (int i = 0; i < n; i++) used[set_label[i]] = 1'b1;
                    pick = 0;
                    while (used[pick]) pick++;
                    set_label[x] = LBL_W'(pick);
                end
            end
        end
        return walls;
    endfunction

    always @(posedge i_clk) begin
        t_row_walls got;
        t_row_walls want;
        if (!i_rst_n) begin
            maze_columns = COLUMNS_RESET;
            restart_labels();
            expected_rows.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.east  = i_out_mon.east_open;
                got.south = i_out_mon.south_open;
                if (expected_rows.size() == 0) begin
                    report($sformatf("row with none pending: east %h south %h",
                                     got.east, got.south));
                end else begin
                    want = expected_rows.pop_front();
                    if (got.east !== want.east) begin
                        report($sformatf("east_open expected %h got %h",
                                         want.east, got.east));
                    end
                    if (got.south !== want.south) begin
                        report($sformatf("south_open expected %h got %h",
                                         want.south, got.south));
                    end
                end
            end
            if (i_cfg_we) begin
                maze_columns = i_cfg_data;
                restart_labels();
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                expected_rows.push_back(carve_row(i_in_mon.horiz_random,
                                                  i_in_mon.vert_random,
                                                  i_in_mon.last_row));
            end
        end
        pending_rows = expected_rows.size();
    end

endmodule

/* bench/tb_eller_maze_row_generator_top.sv */
// testbench top for the eller maze row generator: stimulus, idling, watchdog and verdict
`timescale 1ns / 1ps

module tb_eller_maze_row_generator_top;
    import emr_pkg::*;

    // a quiet stretch this long means the block hung
    localparam int IDLE_LIMIT    = 4000;
    // extra cycles after the last row before a column write or the verdict
    localparam int SETTLE_CYCLES = 2 * MAX_COLUMNS + 8;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [CNT_W-1:0]  cfg_data;

    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int pending_rows;
    int idle_cycles;

    emr_in_if  row_in ();
    emr_out_if row_out ();

    eller_maze_row_generator_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (row_in),
        .o_out      (row_out),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    emr_row_checker u_row_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (row_in),
        .i_out_mon    (row_out),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_rows)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver side: ready drops at random with the current stall rate
    always @(negedge i_clk) begin
        row_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: any transfer on either channel restarts the count
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (row_in.valid && row_in.ready)
                    || (row_out.valid && row_out.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // one row request; entered and left at a falling edge, valid stays up on return
    task automatic send_row(input logic [HORIZ_W-1:0] h, input logic [VERT_W-1:0] v,
                            input logic last);
        // sender gaps, one falling edge at a time
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            row_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        row_in.valid        <= 1'b1;
        row_in.horiz_random <= h;
        row_in.vert_random  <= v;
        row_in.last_row     <= last;
        do begin
            @(posedge i_clk);
        end while (!(row_in.valid && row_in.ready));
        @(negedge i_clk);
    endtask

    // stop sending and wait until every row has come back, plus the row latency
    task automatic drain_rows();
        row_in.valid <= 1'b0;
        while (pending_rows != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // column write only once the block is idle; restarts the maze
    task automatic write_columns(input logic [CNT_W-1:0] value);
        drain_rows();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // random bits of varied density so merges and openings go both ways
    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        case ($urandom_range(3))
            0: w = $urandom;
            1: w = $urandom & $urandom;
            2: w = $urandom | $urandom;
            default: w = {32{1'b1}} & {32{$urandom_range(1) == 1}};
        endcase
        return w;
    endfunction

    // mostly whole mazes (rows closed by a last row), a few stray last-row bits
    task automatic random_mazes(input int rows);
        int          sent;
        int          len;
        logic        last;
        logic [31:0] hw;
        logic [31:0] vw;
        sent = 0;
        while (sent < rows) begin
            len = $urandom_range(1, 10);
            for (int r = 0; r < len && sent < rows; r++) begin
                last = (r == len - 1);
                if ($urandom_range(11) == 0) last = 1'($urandom_range(1));
                hw = rand_word();
                vw = rand_word();
                send_row(hw[HORIZ_W-1:0], vw, last);
                sent++;
            end
        end
    endtask

    // column count per random segment: both ends, out of range values, odd sizes
    function automatic logic [CNT_W-1:0] segment_columns(input int seg);
        logic [CNT_W-1:0] c;
        case (seg)
            0: c = 6'd2;
            1: c = 6'd32;
            2: c = 6'd5;
            3: c = 6'd63;
            4: c = 6'd0;
            5: c = 6'd17;
            6: c = 6'd33;
            7: c = 6'd1;
            default: c = CNT_W'($urandom_range(63));
        endcase
        return c;
    endfunction

    initial begin
        row_in.valid        = 1'b0;
        row_in.horiz_random = '0;
        row_in.vert_random  = '0;
        row_in.last_row     = 1'b0;
        row_out.ready       = 1'b0;
        cfg_we              = 1'b0;
        cfg_data            = '0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        i_rst_n             = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset width of 16 columns: every column its own set, then full merge
        send_row(31'h0, 32'h0, 1'b0);
        send_row(31'h7FFF_FFFF, 32'h0, 1'b0);
        send_row(31'h0, 32'hFFFF_FFFF, 1'b0);
        send_row(31'h2AAA_AAAA, 32'h5555_5555, 1'b0);
        send_row(31'h0, 32'h0, 1'b1);

        // full width: top bits of both fields, last row with and without join bits
        write_columns(6'd32);
        send_row(31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_row(31'h0, 32'h0, 1'b0);
        send_row(31'h7FFF_FFFF, 32'h0, 1'b0);
        send_row(31'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        send_row(31'h7FFF_FFFF, 32'h0, 1'b1);
        send_row(31'h0, 32'hFFFF_FFFF, 1'b1);

        // zero columns act as two
        write_columns(6'd0);
        send_row(31'h0, 32'h0, 1'b0);
        send_row(31'h1, 32'h3, 1'b0);
        send_row(31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);

        // all-ones count acts as the maximum; bits past the width stay closed
        write_columns(6'd63);
        send_row(31'h1234_5678, 32'h9ABC_DEF0, 1'b0);
        send_row(31'h6DB6_DB6D, 32'h2492_4924, 1'b0);
        send_row(31'h0, 32'h0, 1'b1);

        // random segments, each with its own column count and idling mix
        for (int seg = 0; seg < 9; seg++) begin
            write_columns(segment_columns(seg));
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            random_mazes(42);
        end

        drain_rows();
        if (fail_count == 0 && pending_rows == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
